@@ src/uets_pkg.sv @@
// ----------------------------------------------------------------------------
// uets_pkg
// Shared types, constants and codes of the endpoint transfer sequencer.
// ----------------------------------------------------------------------------
package uets_pkg;

   localparam int NUM_ENDPOINTS = 8;
   localparam int BUFFER_BYTES  = 64;
   localparam int EP_W          = 3;
   localparam int LIM_W         = 7;

   typedef enum logic [3:0] {
      OP_SUBMIT     = 4'd0,
      OP_OUT        = 4'd1,
      OP_IN         = 4'd2,
      OP_SETUP      = 4'd3,
      OP_RESET      = 4'd4,
      OP_SUSPEND    = 4'd5,
      OP_SETADDR    = 4'd6,
      OP_STATUSDONE = 4'd7,
      OP_STALL      = 4'd8,
      OP_UNSTALL    = 4'd9,
      OP_CLOSEALL   = 4'd10,
      OP_OPEN       = 4'd11
   } opcode_type;

   localparam logic [1:0] RESP_ACK   = 2'd0;
   localparam logic [1:0] RESP_NAK   = 2'd1;
   localparam logic [1:0] RESP_TOUT  = 2'd2;
   localparam logic [1:0] RESP_STALL = 2'd3;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_XFER    = 3'd1;
   localparam logic [2:0] EV_SETUP   = 3'd2;
   localparam logic [2:0] EV_BUSRST  = 3'd3;
   localparam logic [2:0] EV_SUSPEND = 3'd4;
   localparam logic [2:0] EV_RESUME  = 3'd5;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [2:0]  endpoint;
      logic        direction;
      logic [15:0] xfer_bytes;
      logic [7:0]  rx_length;
      logic        toggle_ok;
      logic        low_speed;
      logic        suspended;
      logic [6:0]  address;
      logic        request_is_set_address;
      logic [9:0]  max_packet;
      logic        is_iso;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [2:0]  event_endpoint;
      logic        event_direction;
      logic [15:0] event_length;
      logic        speed_is_low;
      logic [6:0]  tx_length;
      logic [1:0]  tx_response;
      logic [1:0]  rx_response;
      logic        tx_toggle;
      logic        rx_toggle;
      logic [6:0]  device_address;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_BUILD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic sweep;
      logic [EP_W-1:0] sweep_idx;
      logic build;
   } cmd_type;

   typedef struct packed {
      logic needs_sweep;
   } sts_type;

endpackage

@@ src/uets_if.sv @@
// ----------------------------------------------------------------------------
// uets_req_if / uets_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface uets_req_if import uets_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface uets_rsp_if import uets_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ src/uets_ctrl.sv @@
// ----------------------------------------------------------------------------
// uets_ctrl
// Sequencing state machine: load, execute, sweep, build, respond.
// ----------------------------------------------------------------------------
module uets_ctrl import uets_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type       state_ff, state_in;
   logic [EP_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            idx_in = '0;
            state_in = sts.needs_sweep ? ST_SWEEP : ST_BUILD;
         end
         ST_SWEEP: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == EP_W'(NUM_ENDPOINTS - 1)) state_in = ST_BUILD;
         end
         ST_BUILD: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      in_ready      = (state_ff == ST_IDLE);
      out_valid     = (state_ff == ST_RESP);
      cmd.load      = (state_ff == ST_IDLE) && in_valid;
      cmd.exec      = (state_ff == ST_EXEC);
      cmd.sweep     = (state_ff == ST_SWEEP);
      cmd.sweep_idx = idx_ff;
      cmd.build     = (state_ff == ST_BUILD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

`ifndef SYNTHESIS
   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      !(in_ready && out_valid)) else $error("ready and valid together");
   a_exec_once: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> !cmd.exec) else $error("exec repeated");
   a_load_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.exec) else $error("load not followed by exec");
`endif

endmodule

@@ src/uets_dp.sv @@
// ----------------------------------------------------------------------------
// uets_dp
// Endpoint state registers and event datapath.
// ----------------------------------------------------------------------------
module uets_dp import uets_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp
);

   localparam int N = NUM_ENDPOINTS;

   logic [1:0]       act_ff [N];
   logic [15:0]      rem_ff [N][2];
   logic [15:0]      done_ff[N][2];
   logic [LIM_W-1:0] lim_ff [N][2];
   logic [1:0]       iso_ff [N];
   logic [1:0]       txr_ff [N];
   logic [1:0]       rxr_ff [N];
   logic [N-1:0]     txt_ff, rxt_ff;
   logic [6:0]       arm_ff [N];
   logic             nt_ff, stale_ff, dq_ff;
   logic [6:0]       daddr_ff, baddr_ff;
   req_type          r_ff;
   logic [2:0]       ev_ff;
   logic [2:0]       eve_ff;
   logic             evd_ff;
   logic [15:0]      evl_ff;
   logic             low_ff;
   rsp_type          rsp_ff;

   logic [EP_W-1:0]  ep;
   logic             dir, ok, sw_op;
   assign ep    = r_ff.endpoint;
   assign dir   = r_ff.direction;
   assign ok    = (32'(ep) < N);
   assign sw_op = (r_ff.opcode == OP_RESET) || (r_ff.opcode == OP_CLOSEALL);
   assign sts.needs_sweep = sw_op;
   assign rsp = rsp_ff;

   // IN packet sizing for the addressed endpoint (ep 0 for set address)
   logic [EP_W-1:0] iep;
   logic [15:0]     irem, ilen16;
   logic [6:0]      ilen;
   assign iep    = (r_ff.opcode == OP_SETADDR) ? '0 : ep;
   assign irem   = (r_ff.opcode == OP_SUBMIT || r_ff.opcode == OP_SETADDR)
                   ? ((r_ff.opcode == OP_SETADDR) ? 16'd0 : r_ff.xfer_bytes)
                   : rem_ff[iep][1];
   assign ilen16 = (irem < 16'(lim_ff[iep][1])) ? irem : 16'(lim_ff[iep][1]);
   assign ilen   = ilen16[6:0];

   logic [15:0] orem, olen;
   logic [6:0]  olim;
   assign olim = lim_ff[ep][0];
   always_comb begin
      orem = rem_ff[ep][0];
      olen = (orem < 16'(olim)) ? orem : 16'(olim);
      if (16'(r_ff.rx_length) < olen) olen = 16'(r_ff.rx_length);
   end

   logic [9:0] mpc;
   assign mpc = (r_ff.max_packet > 10'(BUFFER_BYTES)) ? 10'(BUFFER_BYTES) : r_ff.max_packet;

   logic [EP_W-1:0] view;
   logic            vok;
   always_comb begin
      view = (r_ff.opcode == OP_SETUP || r_ff.opcode == OP_SETADDR) ? '0 : ep;
      vok  = (32'(view) < N);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) r_ff <= req;
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            act_ff[i] <= '0; iso_ff[i] <= '0; arm_ff[i] <= '0;
            txr_ff[i] <= RESP_NAK;
            rxr_ff[i] <= (i == 0) ? RESP_ACK : RESP_NAK;
            for (int d = 0; d < 2; d++) begin
               rem_ff[i][d]  <= '0;
               done_ff[i][d] <= '0;
               lim_ff[i][d]  <= (i == 0) ? LIM_W'(BUFFER_BYTES) : '0;
            end
         end
         txt_ff <= '0; rxt_ff <= '0;
         nt_ff <= 1'b1; stale_ff <= 1'b0; dq_ff <= 1'b0;
         daddr_ff <= '0; baddr_ff <= '0;
      end else if (cmd.load) begin
         ev_ff <= EV_NONE; eve_ff <= '0; evd_ff <= 1'b0; evl_ff <= '0; low_ff <= 1'b0;
      end else if (cmd.exec) begin
         case (r_ff.opcode)
            OP_SUBMIT, OP_SETADDR: begin
               if (r_ff.opcode == OP_SETADDR) daddr_ff <= r_ff.address;
               if (ok || r_ff.opcode == OP_SETADDR) begin
                  if (iep == '0) dq_ff <= 1'b0;
                  if (iep == '0 && stale_ff) begin
                     stale_ff <= 1'b0;
                  end else begin
                     if (r_ff.opcode == OP_SUBMIT && !dir) begin
                        act_ff[ep][0]  <= 1'b1;
                        rem_ff[ep][0]  <= r_ff.xfer_bytes;
                        done_ff[ep][0] <= '0;
                        rxr_ff[ep] <= iso_ff[ep][0] ? RESP_TOUT : RESP_ACK;
                     end else begin
                        act_ff[iep][1]  <= 1'b1;
                        rem_ff[iep][1]  <= irem - ilen16;
                        done_ff[iep][1] <= ilen16;
                        arm_ff[iep]     <= ilen;
                        if (iep == '0) begin
                           txr_ff[0] <= RESP_ACK; txt_ff[0] <= nt_ff; nt_ff <= ~nt_ff;
                        end else begin
                           txr_ff[iep] <= iso_ff[iep][1] ? RESP_TOUT : RESP_ACK;
                        end
                     end
                  end
               end
            end
            OP_OUT: begin
               if (ok && (ep == '0 || r_ff.toggle_ok)) begin
                  rxt_ff[ep] <= ~rxt_ff[ep];
                  if (act_ff[ep][0]) begin
                     rem_ff[ep][0]  <= orem - olen;
                     done_ff[ep][0] <= done_ff[ep][0] + olen;
                     if (orem == olen || olen < 16'(olim)) begin
                        act_ff[ep][0] <= 1'b0; rxr_ff[ep] <= RESP_NAK;
                        if (ep == '0) dq_ff <= 1'b1;
                        ev_ff <= EV_XFER; eve_ff <= ep; evd_ff <= 1'b0;
                        evl_ff <= done_ff[ep][0] + olen;
                     end else if (ep == '0) rxr_ff[0] <= RESP_ACK;
                  end
               end
            end
            OP_IN: begin
               if (ok) begin
                  if (ep == '0 && daddr_ff != '0) begin
                     baddr_ff <= daddr_ff; daddr_ff <= '0;
                  end
                  if (ep != '0) txt_ff[ep] <= ~txt_ff[ep];
                  if (act_ff[ep][1]) begin
                     if (irem == '0) begin
                        act_ff[ep][1] <= 1'b0; txr_ff[ep] <= RESP_NAK;
                        if (ep == '0) dq_ff <= 1'b1;
                        ev_ff <= EV_XFER; eve_ff <= ep; evd_ff <= 1'b1;
                        evl_ff <= done_ff[ep][1];
                     end else begin
                        rem_ff[ep][1]  <= irem - ilen16;
                        done_ff[ep][1] <= done_ff[ep][1] + ilen16;
                        arm_ff[ep]     <= ilen;
                        if (ep == '0) begin
                           txr_ff[0] <= RESP_ACK; txt_ff[0] <= nt_ff; nt_ff <= ~nt_ff;
                        end else begin
                           txr_ff[ep] <= iso_ff[ep][1] ? RESP_TOUT : RESP_ACK;
                        end
                     end
                  end
               end
            end
            OP_SETUP: begin
               txt_ff[0] <= 1'b1; rxt_ff[0] <= 1'b1;
               txr_ff[0] <= RESP_NAK; rxr_ff[0] <= RESP_NAK;
               nt_ff <= 1'b1; daddr_ff <= '0;
               stale_ff <= dq_ff; dq_ff <= 1'b0;
               act_ff[0] <= '0;
               ev_ff <= EV_SETUP;
            end
            OP_RESET: begin
               nt_ff <= 1'b1; stale_ff <= 1'b0; dq_ff <= 1'b0;
               daddr_ff <= '0; baddr_ff <= '0;
               lim_ff[0][0] <= LIM_W'(BUFFER_BYTES);
               lim_ff[0][1] <= LIM_W'(BUFFER_BYTES);
               ev_ff <= EV_BUSRST; low_ff <= r_ff.low_speed;
            end
            OP_SUSPEND: ev_ff <= r_ff.suspended ? EV_SUSPEND : EV_RESUME;
            OP_STATUSDONE: begin
               if (r_ff.request_is_set_address) baddr_ff <= r_ff.address;
               dq_ff <= 1'b0;
               if (stale_ff) stale_ff <= 1'b0;
               else begin
                  txr_ff[0] <= RESP_NAK; rxr_ff[0] <= RESP_ACK;
               end
            end
            OP_STALL: begin
               if (ok) begin
                  if (ep == '0) begin
                     txr_ff[0] <= RESP_STALL; rxr_ff[0] <= RESP_STALL;
                     txt_ff[0] <= 1'b1; rxt_ff[0] <= 1'b1;
                  end else if (dir) txr_ff[ep] <= RESP_STALL;
                  else rxr_ff[ep] <= RESP_STALL;
               end
            end
            OP_UNSTALL: begin
               if (ok) begin
                  if (ep == '0) begin
                     if (!dir) rxr_ff[0] <= RESP_ACK;
                  end else if (dir) begin
                     txr_ff[ep] <= RESP_NAK; txt_ff[ep] <= 1'b0;
                  end else begin
                     rxr_ff[ep] <= RESP_ACK; rxt_ff[ep] <= 1'b0;
                  end
               end
            end
            OP_OPEN: begin
               if (ok) begin
                  iso_ff[ep][dir] <= r_ff.is_iso;
                  lim_ff[ep][dir] <= mpc[LIM_W-1:0];
                  if (ep != '0) begin
                     if (dir) begin
                        txt_ff[ep] <= 1'b0; arm_ff[ep] <= '0; txr_ff[ep] <= RESP_NAK;
                     end else begin
                        rxt_ff[ep] <= 1'b0;
                        rxr_ff[ep] <= r_ff.is_iso ? RESP_TOUT : RESP_NAK;
                     end
                  end
               end
            end
            default: ;
         endcase
      end else if (cmd.sweep) begin
         if (r_ff.opcode == OP_RESET) begin
            act_ff[cmd.sweep_idx] <= '0;
            txr_ff[cmd.sweep_idx] <= RESP_NAK;
            rxr_ff[cmd.sweep_idx] <= (cmd.sweep_idx == '0) ? RESP_ACK : RESP_NAK;
            txt_ff[cmd.sweep_idx] <= 1'b0; rxt_ff[cmd.sweep_idx] <= 1'b0;
            arm_ff[cmd.sweep_idx] <= '0;
         end else if (cmd.sweep_idx != '0) begin
            act_ff[cmd.sweep_idx] <= '0; iso_ff[cmd.sweep_idx] <= '0;
            txr_ff[cmd.sweep_idx] <= RESP_NAK; rxr_ff[cmd.sweep_idx] <= RESP_NAK;
            txt_ff[cmd.sweep_idx] <= 1'b0; rxt_ff[cmd.sweep_idx] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.build) begin
         rsp_ff.event_res       <= ev_ff;
         rsp_ff.event_endpoint  <= eve_ff;
         rsp_ff.event_direction <= evd_ff;
         rsp_ff.event_length    <= evl_ff;
         rsp_ff.speed_is_low    <= low_ff;
         rsp_ff.device_address  <= baddr_ff;
         rsp_ff.tx_length       <= vok ? arm_ff[view] : '0;
         rsp_ff.tx_response     <= vok ? txr_ff[view] : '0;
         rsp_ff.rx_response     <= vok ? rxr_ff[view] : '0;
         rsp_ff.tx_toggle       <= vok ? txt_ff[view] : 1'b0;
         rsp_ff.rx_toggle       <= vok ? rxt_ff[view] : 1'b0;
      end
   end

endmodule

@@ src/usb_endpoint_transfer_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// usb_endpoint_transfer_sequencer_core
// Per-endpoint USB transfer length, handshake and toggle sequencer.
// ----------------------------------------------------------------------------
// channel  dir  ports          word
// req      in   req_if (sink)  opcode, endpoint, lengths, flags
// rsp      out  rsp_if (src)   event, endpoint view, address
//
// One word at a time: accept, execute, build, then respond; a new word is
// taken only after the response leaves. Bus reset and close all walk the 8
// endpoint entries between execute and build. Synchronous reset clears the
// controller and endpoint state. Response waits in its register while rsp
// ready is low; req ready stays low until it leaves.
module usb_endpoint_transfer_sequencer_core import uets_pkg::*; (
   input logic         clock,
   input logic         reset,
   uets_req_if.sink    req_if,
   uets_rsp_if.source  rsp_if
);

   cmd_type cmd;
   sts_type sts;

   uets_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   uets_dp u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_if.data),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp_if.data)
   );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives request words into the endpoint transfer sequencer, predicts each
// response word from a behavioral model of the endpoint state, and compares
// every field of the response against the prediction.
// ----------------------------------------------------------------------------
module testbench;
   import uets_pkg::*;

   class rsp_scoreboard;
      rsp_type pending[$];
      int      errors = 0;

      function void note(rsp_type w);
         pending.push_back(w);
      endfunction

      function void check(rsp_type got);
         rsp_type exp;
         if (pending.size() == 0) begin
            $error("unexpected response word %h", got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.event_res !== exp.event_res) begin
            $error("event_res exp %0d got %0d", exp.event_res, got.event_res); errors++;
         end
         if (got.event_endpoint !== exp.event_endpoint) begin
            $error("event_endpoint exp %0d got %0d", exp.event_endpoint, got.event_endpoint);
            errors++;
         end
         if (got.event_direction !== exp.event_direction) begin
            $error("event_direction exp %0d got %0d", exp.event_direction,
                   got.event_direction); errors++;
         end
         if (got.event_length !== exp.event_length) begin
            $error("event_length exp %0d got %0d", exp.event_length, got.event_length);
            errors++;
         end
         if (got.speed_is_low !== exp.speed_is_low) begin
            $error("speed_is_low exp %0d got %0d", exp.speed_is_low, got.speed_is_low);
            errors++;
         end
         if (got.tx_length !== exp.tx_length) begin
            $error("tx_length exp %0d got %0d", exp.tx_length, got.tx_length); errors++;
         end
         if (got.tx_response !== exp.tx_response) begin
            $error("tx_response exp %0d got %0d", exp.tx_response, got.tx_response); errors++;
         end
         if (got.rx_response !== exp.rx_response) begin
            $error("rx_response exp %0d got %0d", exp.rx_response, got.rx_response); errors++;
         end
         if (got.tx_toggle !== exp.tx_toggle) begin
            $error("tx_toggle exp %0d got %0d", exp.tx_toggle, got.tx_toggle); errors++;
         end
         if (got.rx_toggle !== exp.rx_toggle) begin
            $error("rx_toggle exp %0d got %0d", exp.rx_toggle, got.rx_toggle); errors++;
         end
         if (got.device_address !== exp.device_address) begin
            $error("device_address exp %0d got %0d", exp.device_address,
                   got.device_address); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   always #5 clock = ~clock;

   uets_req_if req_if ();
   uets_rsp_if rsp_if ();

   usb_endpoint_transfer_sequencer_core dut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source)
   );

   // endpoint model state, index [ep][dir]
   logic        m_active [NUM_ENDPOINTS][2];
   logic [15:0] m_remain [NUM_ENDPOINTS][2];
   logic [15:0] m_done   [NUM_ENDPOINTS][2];
   logic [6:0]  m_limit  [NUM_ENDPOINTS][2];
   logic        m_iso    [NUM_ENDPOINTS][2];
   logic [1:0]  m_txr [NUM_ENDPOINTS];
   logic [1:0]  m_rxr [NUM_ENDPOINTS];
   logic        m_txt [NUM_ENDPOINTS];
   logic        m_rxt [NUM_ENDPOINTS];
   logic [6:0]  m_arm [NUM_ENDPOINTS];
   logic        m_ep0_tog, m_stale, m_ep0_done;
   logic [6:0]  m_defer, m_addr;
   rsp_type     ev;

   rsp_scoreboard sb;
   int send_idle, recv_idle;

   task automatic model_reset();
      for (int i = 0; i < NUM_ENDPOINTS; i++) begin
         for (int d = 0; d < 2; d++) begin
            m_active[i][d] = 0; m_remain[i][d] = 0; m_done[i][d] = 0;
            m_limit[i][d] = 0; m_iso[i][d] = 0;
         end
         m_txr[i] = RESP_NAK; m_rxr[i] = RESP_NAK;
         m_txt[i] = 0; m_rxt[i] = 0; m_arm[i] = 0;
      end
      m_limit[0][0] = BUFFER_BYTES; m_limit[0][1] = BUFFER_BYTES;
      m_rxr[0] = RESP_ACK;
      m_ep0_tog = 1; m_stale = 0; m_ep0_done = 0; m_defer = 0; m_addr = 0;
   endtask

   function automatic void xfer_finish(int ep, int dir);
      m_active[ep][dir] = 0;
      if (dir) m_txr[ep] = RESP_NAK; else m_rxr[ep] = RESP_NAK;
      if (ep == 0) m_ep0_done = 1;
      ev.event_res = EV_XFER; ev.event_endpoint = ep;
      ev.event_direction = dir; ev.event_length = m_done[ep][dir];
   endfunction

   function automatic void arm_in(int ep, bit force_arm);
      int len;
      if (!m_active[ep][1]) return;
      if (!force_arm && m_remain[ep][1] == 0) begin
         xfer_finish(ep, 1);
         return;
      end
      len = m_limit[ep][1];
      if (m_remain[ep][1] < len) len = m_remain[ep][1];
      m_remain[ep][1] -= len;
      m_done[ep][1] += len;
      m_arm[ep] = len;
      if (ep == 0) begin
         m_txr[0] = RESP_ACK; m_txt[0] = m_ep0_tog; m_ep0_tog ^= 1;
      end else begin
         m_txr[ep] = m_iso[ep][1] ? RESP_TOUT : RESP_ACK;
      end
   endfunction

   function automatic void take_out(int ep, int rx);
      int len, lim;
      lim = m_limit[ep][0];
      if (!m_active[ep][0]) return;
      len = lim;
      if (m_remain[ep][0] < len) len = m_remain[ep][0];
      if (rx < len) len = rx;
      m_remain[ep][0] -= len;
      m_done[ep][0] += len;
      if (m_remain[ep][0] == 0 || len < lim) xfer_finish(ep, 0);
      else if (ep == 0) m_rxr[0] = RESP_ACK;
   endfunction

   function automatic void submit_xfer(int ep, int dir, logic [15:0] total);
      if (ep == 0) begin
         m_ep0_done = 0;
         if (m_stale) begin
            m_stale = 0;
            return;
         end
      end
      m_active[ep][dir] = 1; m_remain[ep][dir] = total; m_done[ep][dir] = 0;
      if (dir) arm_in(ep, 1);
      else m_rxr[ep] = m_iso[ep][0] ? RESP_TOUT : RESP_ACK;
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      int ep, dir, view;
      ep = r.endpoint; dir = r.direction; view = ep;
      ev = '0;
      case (r.opcode)
         OP_SUBMIT: submit_xfer(ep, dir, r.xfer_bytes);
         OP_OUT: begin
            if (ep == 0 || r.toggle_ok) begin
               m_rxt[ep] ^= 1;
               take_out(ep, r.rx_length);
            end
         end
         OP_IN: begin
            if (ep == 0 && m_defer != 0) begin
               m_addr = m_defer; m_defer = 0;
            end
            if (ep != 0) m_txt[ep] ^= 1;
            arm_in(ep, 0);
         end
         OP_SETUP: begin
            view = 0;
            m_txt[0] = 1; m_rxt[0] = 1; m_txr[0] = RESP_NAK; m_rxr[0] = RESP_NAK;
            m_ep0_tog = 1; m_defer = 0; m_stale = m_ep0_done; m_ep0_done = 0;
            m_active[0][0] = 0; m_active[0][1] = 0;
            ev.event_res = EV_SETUP;
         end
         OP_RESET: begin
            m_ep0_tog = 1; m_stale = 0; m_ep0_done = 0; m_defer = 0;
            for (int i = 0; i < NUM_ENDPOINTS; i++) begin
               m_active[i][0] = 0; m_active[i][1] = 0;
               m_txr[i] = RESP_NAK; m_rxr[i] = RESP_NAK;
               m_txt[i] = 0; m_rxt[i] = 0; m_arm[i] = 0;
            end
            m_rxr[0] = RESP_ACK;
            m_limit[0][0] = BUFFER_BYTES; m_limit[0][1] = BUFFER_BYTES;
            m_addr = 0;
            ev.event_res = EV_BUSRST; ev.speed_is_low = r.low_speed;
         end
         OP_SUSPEND: ev.event_res = r.suspended ? EV_SUSPEND : EV_RESUME;
         OP_SETADDR: begin
            view = 0; m_defer = r.address;
            submit_xfer(0, 1, 0);
         end
         OP_STATUSDONE: begin
            if (r.request_is_set_address) m_addr = r.address;
            m_ep0_done = 0;
            if (m_stale) m_stale = 0;
            else begin
               m_txr[0] = RESP_NAK; m_rxr[0] = RESP_ACK;
            end
         end
         OP_STALL: begin
            if (ep == 0) begin
               m_txr[0] = RESP_STALL; m_rxr[0] = RESP_STALL; m_txt[0] = 1; m_rxt[0] = 1;
            end else if (dir) m_txr[ep] = RESP_STALL;
            else m_rxr[ep] = RESP_STALL;
         end
         OP_UNSTALL: begin
            if (ep == 0) begin
               if (!dir) m_rxr[0] = RESP_ACK;
            end else if (dir) begin
               m_txr[ep] = RESP_NAK; m_txt[ep] = 0;
            end else begin
               m_rxr[ep] = RESP_ACK; m_rxt[ep] = 0;
            end
         end
         OP_CLOSEALL: begin
            for (int i = 1; i < NUM_ENDPOINTS; i++) begin
               m_active[i][0] = 0; m_active[i][1] = 0; m_iso[i][0] = 0; m_iso[i][1] = 0;
               m_txr[i] = RESP_NAK; m_rxr[i] = RESP_NAK; m_txt[i] = 0; m_rxt[i] = 0;
            end
         end
         OP_OPEN: begin
            m_iso[ep][dir] = r.is_iso;
            m_limit[ep][dir] = (r.max_packet > BUFFER_BYTES) ? BUFFER_BYTES : r.max_packet;
            if (ep != 0) begin
               if (dir) begin
                  m_txt[ep] = 0; m_arm[ep] = 0; m_txr[ep] = RESP_NAK;
               end else begin
                  m_rxt[ep] = 0; m_rxr[ep] = r.is_iso ? RESP_TOUT : RESP_NAK;
               end
            end
         end
         default: ;
      endcase
      ev.tx_length = m_arm[view]; ev.tx_response = m_txr[view];
      ev.rx_response = m_rxr[view]; ev.tx_toggle = m_txt[view];
      ev.rx_toggle = m_rxt[view]; ev.device_address = m_addr;
      return ev;
   endfunction

   function automatic req_type rand_word();
      req_type r;
      r.opcode = $urandom; r.endpoint = $urandom; r.direction = $urandom;
      r.xfer_bytes = $urandom; r.rx_length = $urandom; r.toggle_ok = $urandom;
      r.low_speed = $urandom; r.suspended = $urandom; r.address = $urandom;
      r.request_is_set_address = $urandom; r.max_packet = $urandom; r.is_iso = $urandom;
      return r;
   endfunction

   // mostly transfer traffic with short lengths so transfers complete
   function automatic req_type traffic_word();
      req_type r;
      int pick;
      r = rand_word();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         r.opcode = OP_SUBMIT;
         if ($urandom_range(0, 9) != 0) r.xfer_bytes = $urandom_range(0, 200);
      end else if (pick < 40) begin
         r.opcode = OP_OUT;
         if ($urandom_range(0, 3) != 0) r.toggle_ok = 1;
         if ($urandom_range(0, 2) == 0) r.rx_length = 64;
      end else if (pick < 65) r.opcode = OP_IN;
      else if (pick < 73) begin
         r.opcode = OP_OPEN;
         if ($urandom_range(0, 3) != 0) r.max_packet = $urandom_range(1, 80);
      end else if (pick < 78) r.opcode = OP_SETUP;
      else if (pick < 83) r.opcode = OP_STATUSDONE;
      else if (pick < 86) r.opcode = OP_SETADDR;
      else if (pick < 89) r.opcode = OP_STALL;
      else if (pick < 92) r.opcode = OP_UNSTALL;
      if (pick < 92 && $urandom_range(0, 3) == 0) r.endpoint = 0;
      return r;
   endfunction

   // valid stays high after an accept; callers drop it before any pause
   task automatic send_word(req_type r);
      while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
         req_if.valid <= 0;
         @(posedge clock);
      end
      req_if.valid <= 1;
      req_if.data  <= r;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note(predict_rsp(r));
   endtask

   task automatic send_op(opcode_type op, int ep, int dir);
      req_type r;
      r = rand_word();
      r.opcode = op; r.endpoint = ep; r.direction = dir;
      send_word(r);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) sb.check(rsp_if.data);
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   initial begin
      #20_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   initial begin
      req_type r;
      sb = new();
      model_reset();
      send_idle = 33; recv_idle = 46;
      req_if.valid = 0; req_if.data = '0; rsp_if.ready = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed
      send_op(OP_RESET, 0, 0);
      send_op(OP_SUSPEND, 0, 0);
      r = rand_word(); r.opcode = OP_OPEN; r.endpoint = 1; r.direction = 1;
      r.max_packet = 10'h3FF; r.is_iso = 0; send_word(r);
      r = rand_word(); r.opcode = OP_OPEN; r.endpoint = 2; r.direction = 0;
      r.max_packet = 8; r.is_iso = 1; send_word(r);
      r = rand_word(); r.opcode = OP_SUBMIT; r.endpoint = 1; r.direction = 1;
      r.xfer_bytes = 100; send_word(r);
      send_op(OP_IN, 1, 1); send_op(OP_IN, 1, 1);
      r = rand_word(); r.opcode = OP_SUBMIT; r.endpoint = 2; r.direction = 0;
      r.xfer_bytes = 16'hFFFF; send_word(r);
      r = rand_word(); r.opcode = OP_OUT; r.endpoint = 2; r.toggle_ok = 1;
      r.rx_length = 8'hFF; send_word(r);
      r.rx_length = 0; send_word(r);
      r = rand_word(); r.opcode = OP_SUBMIT; r.endpoint = 3; r.direction = 1;
      r.xfer_bytes = 5; send_word(r);   // never opened endpoint
      send_op(OP_IN, 3, 1);
      r = rand_word(); r.opcode = OP_SUBMIT; r.endpoint = 0; r.direction = 0;
      r.xfer_bytes = 3; send_word(r);
      r = rand_word(); r.opcode = OP_OUT; r.endpoint = 0; r.rx_length = 3; send_word(r);
      send_op(OP_SETUP, 0, 0);            // follows a completion: stale arm
      r = rand_word(); r.opcode = OP_SETADDR; r.address = 7'h7F; send_word(r);
      send_op(OP_IN, 0, 1);
      r = rand_word(); r.opcode = OP_STATUSDONE; r.request_is_set_address = 1;
      r.address = 7'h55; send_word(r);
      send_op(OP_STALL, 0, 0); send_op(OP_STALL, 4, 1);
      send_op(OP_UNSTALL, 0, 0); send_op(OP_UNSTALL, 4, 1);
      send_op(OP_CLOSEALL, 0, 0);
      r = rand_word(); r.opcode = 4'd15; send_word(r);
      r = rand_word(); r.opcode = 4'd12; send_word(r);

      for (int n = 0; n < 1500; n++) begin
         if (n == 500) begin
            send_idle = 46; recv_idle = 33;
         end else if (n == 1000) begin
            send_idle = 0; recv_idle = 0;
         end
         if (n == 750) begin
            req_if.valid <= 0;
            @(posedge clock);
            while (sb.pending.size() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 9) == 0) r = rand_word();
         else r = traffic_word();
         send_word(r);
      end

      req_if.valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end
endmodule
